// ===== rtl/crcg_pkg.sv =====
// ----------------------------------------------------------------------------
// crcg_pkg
// Shared types and constants of the Catmull-Rom curve generator.
// ----------------------------------------------------------------------------
package crcg_pkg;

    localparam int OUT_W       = 26;
    localparam int OUT_TDATA_W = 56;
    localparam int TQ_W        = 16;

    // operand sources of a segment job
    localparam logic [2:0] SEL_R0  = 3'd0;
    localparam logic [2:0] SEL_R1  = 3'd1;
    localparam logic [2:0] SEL_R2  = 3'd2;
    localparam logic [2:0] SEL_CUR = 3'd3;
    localparam logic [2:0] SEL_F0  = 3'd4;
    localparam logic [2:0] SEL_F1  = 3'd5;
    localparam logic [2:0] SEL_F2  = 3'd6;

    // register indexes
    localparam logic REG_PPS    = 1'b0;
    localparam logic REG_CLOSED = 1'b1;

    typedef struct packed {
        logic            pt;   // emit the current point itself
        logic [3:0][2:0] sel;  // sel[0] is the first curve point
    } job_t;

    typedef struct packed {
        logic start;
    } eval_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eval_sts_t;

    // floor(65536/N) and 65536 mod N
    localparam logic [16:0] TQ_STEP [0:16] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
        17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
        17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096
    };
    localparam logic [3:0] TQ_REM [0:16] = '{
        4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd4, 4'd2, 4'd0,
        4'd7, 4'd6, 4'd9, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
    };

endpackage

// ===== rtl/crcg_eval.sv =====
// ----------------------------------------------------------------------------
// crcg_eval
// Bit-serial Horner evaluator: round(128*(a0 + a1 t + a2 t^2 + a3 t^3)).
// ----------------------------------------------------------------------------
module crcg_eval #(
    parameter int CA_W = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  crcg_pkg::eval_ctl_t           ctl,
    input  logic signed [CA_W-1:0]        a0,
    input  logic signed [CA_W-1:0]        a1,
    input  logic signed [CA_W-1:0]        a2,
    input  logic signed [CA_W-1:0]        a3,
    input  logic [crcg_pkg::TQ_W-1:0]     tq,
    output crcg_pkg::eval_sts_t           sts,
    output logic signed [crcg_pkg::OUT_W-1:0] result
);

    localparam int ACC_W = CA_W + 53;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << 40;

    logic signed [ACC_W-1:0] m_reg, prod_reg, acc_reg;
    logic signed [CA_W-1:0]  a0_reg, a1_reg, a2_reg;
    logic [crcg_pkg::TQ_W-1:0] tq_reg;
    logic [4:0] bit_reg;
    logic [1:0] pass_reg;
    logic       busy_reg, done_reg;
    logic signed [ACC_W-1:0] term, sum, rnd_sum;

    always_comb
    begin
        case (pass_reg)
            2'd0:    term = ACC_W'(a2_reg) <<< 16;
            2'd1:    term = ACC_W'(a1_reg) <<< 32;
            default: term = ACC_W'(a0_reg) <<< 48;
        endcase
        sum     = prod_reg + term;
        rnd_sum = (acc_reg + RND) >>> 41;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            pass_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                bit_reg  <= '0;
                pass_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!bit_reg[4])
                    bit_reg <= bit_reg + 5'd1;
                else if (pass_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg  <= '0;
                    pass_reg <= pass_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            m_reg    <= ACC_W'(a3);
            prod_reg <= '0;
            a0_reg   <= a0;
            a1_reg   <= a1;
            a2_reg   <= a2;
            tq_reg   <= tq;
        end
        else if (busy_reg)
        begin
            if (!bit_reg[4])
                prod_reg <= (prod_reg <<< 1) + (tq_reg[~bit_reg[3:0]] ? m_reg : '0);
            else if (pass_reg == 2'd2)
                acc_reg <= sum;
            else
            begin
                m_reg    <= sum;
                prod_reg <= '0;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = crcg_pkg::OUT_W'(rnd_sum);

endmodule

// ===== rtl/catmull_rom_curve_generator.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_generator
// Uniform Catmull-Rom spline sampler over a stream of 2-D control points.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  s_axis    in   control point: tdata {point_y, point_x}, tlast final_point
//  m_axis    out  curve sample: tdata {curve_y, curve_x}, tlast last_of_run
//  apb       in   0x0 points_per_segment, 0x4 closed_curve
//
//  A point is accepted, then each segment job loads its four operands and emits N
//  samples; the end point sample of an open curve follows the last job.
//  For each sample, x and then y each take a start state and three bit-serial Horner
//  passes ended by a done strobe, then the sample is offered on m_axis.
//  s_axis_tready is high only while idle; a sample waits in place for m_axis_tready.
//  Reset clears control state and the point count; stored points are unset.
// ----------------------------------------------------------------------------
module catmull_rom_curve_generator #(
    parameter int MAX_SAMPLES_PER_SEGMENT = 16,
    parameter int COORD_BITS              = 16,
    localparam int IN_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_W-1:0]       s_axis_tdata,   // point_x, point_y
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [crcg_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // curve_x, curve_y
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CW   = COORD_BITS;
    localparam int CA_W = CW + 4;
    localparam int K_W  = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_JOB  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_EVX  = 3'd3;
    localparam logic [2:0] ST_WX   = 3'd4;
    localparam logic [2:0] ST_EVY  = 3'd5;
    localparam logic [2:0] ST_WY   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [4:0] pps_reg;
    logic       closed_reg;
    logic [2:0] seen_reg;
    logic [2:0] job_cnt_reg;
    logic [2:0] job_idx_reg;
    logic [1:0] ld_reg;
    logic [K_W-1:0] k_reg;
    logic [16:0] tq_reg;
    logic [3:0]  rm_reg;
    crcg_pkg::job_t job_reg [0:3];
    crcg_pkg::job_t jobs_next [0:3];
    logic [2:0] jcnt_next;

    logic signed [CW-1:0] r_x_reg [0:2];
    logic signed [CW-1:0] r_y_reg [0:2];
    logic signed [CW-1:0] f_x_reg [0:2];
    logic signed [CW-1:0] f_y_reg [0:2];
    logic signed [CW-1:0] cur_x_reg, cur_y_reg;
    logic signed [CW-1:0] p_x_reg [0:3];
    logic signed [CW-1:0] p_y_reg [0:3];
    logic signed [crcg_pkg::OUT_W-1:0] out_x_reg, out_y_reg;

    logic signed [CW-1:0] in_x, in_y, mux_x, mux_y;
    logic signed [CW+7:0] pt_x, pt_y;
    logic signed [CA_W-1:0] e1, e2, e3, e4, a0, a1, a2, a3;
    logic [K_W-1:0] n_eff;
    logic [4:0] r_sum;
    logic       in_acc, cfg_wr, out_acc, job_end, job_last, seg_last, use_y;
    logic [2:0] cur_sel;
    crcg_pkg::job_t cur_job;
    crcg_pkg::eval_ctl_t ev_ctl;
    crcg_pkg::eval_sts_t ev_sts;
    logic signed [crcg_pkg::OUT_W-1:0] ev_result;

    assign in_x    = s_axis_tdata[CW-1:0];
    assign in_y    = s_axis_tdata[2*CW-1:CW];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb
    begin
        if (paddr[2] == crcg_pkg::REG_CLOSED)
            prdata = {31'd0, closed_reg};
        else
            prdata = {27'd0, pps_reg};
    end

    always_comb
    begin
        if (pps_reg == 5'd0)
            n_eff = K_W'(1);
        else if (pps_reg > 5'(MAX_SAMPLES_PER_SEGMENT))
            n_eff = K_W'(MAX_SAMPLES_PER_SEGMENT);
        else
            n_eff = K_W'(pps_reg);
    end

    // job list for the arriving point
    always_comb
    begin
        jcnt_next = '0;
        for (int i = 0; i < 4; i++)
            jobs_next[i] = '0;
        if (seen_reg >= 3'd3)
        begin
            jobs_next[0].sel = {crcg_pkg::SEL_CUR, crcg_pkg::SEL_R2,
                                crcg_pkg::SEL_R1, crcg_pkg::SEL_R0};
            jcnt_next = 3'd1;
        end
        else if (seen_reg == 3'd2 && !closed_reg)
        begin
            jobs_next[0].sel = {crcg_pkg::SEL_CUR, crcg_pkg::SEL_R2,
                                crcg_pkg::SEL_R1, crcg_pkg::SEL_R1};
            jcnt_next = 3'd1;
        end
        if (s_axis_tlast)
        begin
            if (seen_reg == 3'd1)
            begin
                jobs_next[jcnt_next[1:0]].sel = {crcg_pkg::SEL_CUR, crcg_pkg::SEL_CUR,
                                                 crcg_pkg::SEL_R2, crcg_pkg::SEL_R2};
                jcnt_next = jcnt_next + 3'd1;
            end
            else if (seen_reg >= 3'd2)
            begin
                if (closed_reg)
                begin
                    jobs_next[jcnt_next[1:0]].sel = {crcg_pkg::SEL_F0, crcg_pkg::SEL_CUR,
                                                     crcg_pkg::SEL_R2, crcg_pkg::SEL_R1};
                    jobs_next[2'(jcnt_next + 3'd1)].sel = {crcg_pkg::SEL_F1,
                        crcg_pkg::SEL_F0, crcg_pkg::SEL_CUR, crcg_pkg::SEL_R2};
                    jobs_next[2'(jcnt_next + 3'd2)].sel = {crcg_pkg::SEL_F2,
                        crcg_pkg::SEL_F1, crcg_pkg::SEL_F0, crcg_pkg::SEL_CUR};
                    jcnt_next = jcnt_next + 3'd3;
                end
                else
                begin
                    jobs_next[jcnt_next[1:0]].sel = {crcg_pkg::SEL_CUR, crcg_pkg::SEL_CUR,
                                                     crcg_pkg::SEL_R2, crcg_pkg::SEL_R1};
                    jcnt_next = jcnt_next + 3'd1;
                end
            end
            if (!closed_reg)
            begin
                jobs_next[jcnt_next[1:0]].pt = 1'b1;
                jcnt_next = jcnt_next + 3'd1;
            end
        end
    end

    assign cur_job = job_reg[job_idx_reg[1:0]];
    assign cur_sel = cur_job.sel[ld_reg];

    always_comb
    begin
        unique case (cur_sel)
            crcg_pkg::SEL_R0:  begin mux_x = r_x_reg[0]; mux_y = r_y_reg[0]; end
            crcg_pkg::SEL_R1:  begin mux_x = r_x_reg[1]; mux_y = r_y_reg[1]; end
            crcg_pkg::SEL_R2:  begin mux_x = r_x_reg[2]; mux_y = r_y_reg[2]; end
            crcg_pkg::SEL_F0:  begin mux_x = f_x_reg[0]; mux_y = f_y_reg[0]; end
            crcg_pkg::SEL_F1:  begin mux_x = f_x_reg[1]; mux_y = f_y_reg[1]; end
            crcg_pkg::SEL_F2:  begin mux_x = f_x_reg[2]; mux_y = f_y_reg[2]; end
            default:           begin mux_x = cur_x_reg;  mux_y = cur_y_reg;  end
        endcase
    end

    // spline coefficients, times two
    assign use_y = (state_reg == ST_EVY);
    assign e1 = CA_W'(use_y ? p_y_reg[0] : p_x_reg[0]);
    assign e2 = CA_W'(use_y ? p_y_reg[1] : p_x_reg[1]);
    assign e3 = CA_W'(use_y ? p_y_reg[2] : p_x_reg[2]);
    assign e4 = CA_W'(use_y ? p_y_reg[3] : p_x_reg[3]);
    assign a0 = e2 <<< 1;
    assign a1 = e3 - e1;
    assign a2 = (e1 <<< 1) - (e2 <<< 2) - e2 + (e3 <<< 2) - e4;
    assign a3 = e2 + (e2 <<< 1) - e1 - e3 - (e3 <<< 1) + e4;

    assign ev_ctl.start = (state_reg == ST_EVX) || (state_reg == ST_EVY);

    crcg_eval #(
        .CA_W (CA_W)
    ) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ev_ctl),
        .a0     (a0),
        .a1     (a1),
        .a2     (a2),
        .a3     (a3),
        .tq     (tq_reg[crcg_pkg::TQ_W-1:0]),
        .sts    (ev_sts),
        .result (ev_result)
    );

    assign pt_x     = {cur_x_reg, 8'h00};
    assign pt_y     = {cur_y_reg, 8'h00};
    assign job_end  = (job_idx_reg == job_cnt_reg);
    assign job_last = ((job_idx_reg + 3'd1) == job_cnt_reg);
    assign seg_last = (k_reg == n_eff - K_W'(1));
    assign r_sum    = 5'(rm_reg) + 5'(crcg_pkg::TQ_REM[5'(n_eff)]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_JOB;
            ST_JOB:
            begin
                if (job_end)
                    state_next = ST_IDLE;
                else if (cur_job.pt)
                    state_next = ST_OUT;
                else
                    state_next = ST_LOAD;
            end
            ST_LOAD: if (ld_reg == 2'd3) state_next = ST_EVX;
            ST_EVX:  state_next = ST_WX;
            ST_WX:   if (ev_sts.done) state_next = ST_EVY;
            ST_EVY:  state_next = ST_WY;
            ST_WY:   if (ev_sts.done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (cur_job.pt || seg_last)
                        state_next = ST_JOB;
                    else
                        state_next = ST_EVX;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pps_reg     <= 5'd16;
            closed_reg  <= 1'b0;
            seen_reg    <= '0;
            job_cnt_reg <= '0;
            job_idx_reg <= '0;
            ld_reg      <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                if (paddr[2] == crcg_pkg::REG_CLOSED)
                    closed_reg <= pwdata[0];
                else
                    pps_reg <= pwdata[4:0];
            end
            if (in_acc)
            begin
                job_cnt_reg <= jcnt_next;
                job_idx_reg <= '0;
                if (s_axis_tlast)
                    seen_reg <= '0;
                else if (seen_reg < 3'd4)
                    seen_reg <= seen_reg + 3'd1;
            end
            if (state_reg == ST_JOB)
                ld_reg <= '0;
            else if (state_reg == ST_LOAD)
                ld_reg <= ld_reg + 2'd1;
            if (state_reg == ST_LOAD)
                k_reg <= '0;
            else if (state_reg == ST_OUT && out_acc)
            begin
                if (cur_job.pt || seg_last)
                    job_idx_reg <= job_idx_reg + 3'd1;
                else
                    k_reg <= k_reg + K_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_x_reg <= in_x;
            cur_y_reg <= in_y;
            for (int i = 0; i < 4; i++)
                job_reg[i] <= jobs_next[i];
            for (int i = 0; i < 3; i++)
            begin
                if (seen_reg == 3'(i))
                begin
                    f_x_reg[i] <= in_x;
                    f_y_reg[i] <= in_y;
                end
            end
        end
        if (state_reg == ST_JOB && job_end)
        begin
            r_x_reg[0] <= r_x_reg[1];
            r_x_reg[1] <= r_x_reg[2];
            r_x_reg[2] <= cur_x_reg;
            r_y_reg[0] <= r_y_reg[1];
            r_y_reg[1] <= r_y_reg[2];
            r_y_reg[2] <= cur_y_reg;
        end
        if (state_reg == ST_JOB && cur_job.pt)
        begin
            out_x_reg <= crcg_pkg::OUT_W'(pt_x);
            out_y_reg <= crcg_pkg::OUT_W'(pt_y);
        end
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_x_reg[i] <= p_x_reg[i+1];
                p_y_reg[i] <= p_y_reg[i+1];
            end
            p_x_reg[3] <= mux_x;
            p_y_reg[3] <= mux_y;
            tq_reg     <= '0;
            rm_reg     <= '0;
        end
        if (state_reg == ST_OUT && out_acc)
        begin
            if (r_sum >= 5'(n_eff))
            begin
                rm_reg <= 4'(r_sum - 5'(n_eff));
                tq_reg <= tq_reg + crcg_pkg::TQ_STEP[5'(n_eff)] + 17'd1;
            end
            else
            begin
                rm_reg <= 4'(r_sum);
                tq_reg <= tq_reg + crcg_pkg::TQ_STEP[5'(n_eff)];
            end
        end
        if (state_reg == ST_WX && ev_sts.done)
            out_x_reg <= ev_result;
        if (state_reg == ST_WY && ev_sts.done)
            out_y_reg <= ev_result;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tlast  = job_last && (cur_job.pt || seg_last);
    assign m_axis_tdata  = {4'd0, out_y_reg, out_x_reg};

    a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("sample offered while idle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ev_sts.done |-> (state_reg == ST_WX || state_reg == ST_WY))
        else $error("evaluator finished outside a wait state");

    a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        ev_ctl.start |-> !ev_sts.busy)
        else $error("evaluator restarted while busy");

    a_job_count: assert property (@(posedge clk) disable iff (!rst_n)
        job_idx_reg <= job_cnt_reg && job_cnt_reg <= 3'd4)
        else $error("job index out of range");

endmodule

// ===== tb/sv/catmull_rom_curve_generator_test.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_curve_generator_test
// Streams control-point curves through the generator under several segment
// lengths and both curve modes, predicts samples with a local fixed-point
// Catmull-Rom model or directed expected values, and checks samples in order.
// ----------------------------------------------------------------------------
module catmull_rom_curve_generator_test;

    typedef struct {
        logic [25:0] cx;
        logic [25:0] cy;
        logic        last;
    } sample_t;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic        fin;
        logic        typed;
        logic [25:0] ex;
        logic [25:0] ey;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // point_x, point_y
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [crcg_pkg::OUT_TDATA_W-1:0] m_axis_tdata; // curve_x, curve_y
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    catmull_rom_curve_generator dut (.*);

    longint    recent_x[3], recent_y[3], first_x[3], first_y[3];
    int        seen_cnt;
    int        seg_len;
    bit        loop_mode;
    sample_t   sample_q[$];
    sample_t   step_q[$];
    int        errors;
    bit        rx_quiet;
    bit        tx_quiet;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint cubic_at(longint p1, longint p2, longint p3, longint p4,
                                        longint tq);
        longint a0, a1, a2, a3, h2, h1, hi, lo, c, d;
        a0 = 2 * p2;
        a1 = p3 - p1;
        a2 = 2 * p1 - 5 * p2 + 4 * p3 - p4;
        a3 = -p1 + 3 * p2 - 3 * p3 + p4;
        h2 = a3 * tq + a2 * 65536;
        h1 = h2 * tq + a1 * (64'sd1 <<< 32);
        hi = h1 >>> 25;
        lo = h1 - hi * (64'sd1 <<< 25);
        c  = hi * tq + a0 * (64'sd1 <<< 23);
        d  = lo * tq + (64'sd1 <<< 40);
        return (c + (d >>> 25)) >>> 16;
    endfunction

    function automatic void add_sample(longint x, longint y);
        sample_t s;
        s.cx = x[25:0];
        s.cy = y[25:0];
        s.last = 1'b0;
        step_q = {step_q, s};
    endfunction

    function automatic void add_segment(int a, int b, int c, int e,
                                        longint px[7], longint py[7]);
        int     n;
        longint tq;
        n = (seg_len == 0) ? 1 : (seg_len > 16 ? 16 : seg_len);
        for (int k = 0; k < n; k++)
        begin
            tq = (k * 65536) / n;
            add_sample(cubic_at(px[a], px[b], px[c], px[e], tq),
                       cubic_at(py[a], py[b], py[c], py[e], tq));
        end
    endfunction

    // operand slots: 0..2 recent, 3 current, 4..6 first points
    function automatic void predict_point(logic [15:0] x, logic [15:0] y, logic fin);
        longint px[7], py[7];
        int     c;
        c = seen_cnt;
        step_q.delete();
        if (c < 3)
        begin
            first_x[c] = longint'(signed'(x));
            first_y[c] = longint'(signed'(y));
        end
        for (int i = 0; i < 3; i++)
        begin
            px[i] = recent_x[i]; py[i] = recent_y[i];
            px[i+4] = first_x[i]; py[i+4] = first_y[i];
        end
        px[3] = longint'(signed'(x));
        py[3] = longint'(signed'(y));
        if (c >= 3)
            add_segment(0, 1, 2, 3, px, py);
        else if (c == 2 && !loop_mode)
            add_segment(1, 1, 2, 3, px, py);
        if (fin)
        begin
            if (c == 1)
                add_segment(2, 2, 3, 3, px, py);
            else if (c >= 2)
            begin
                if (loop_mode)
                begin
                    add_segment(1, 2, 3, 4, px, py);
                    add_segment(2, 3, 4, 5, px, py);
                    add_segment(3, 4, 5, 6, px, py);
                end
                else
                    add_segment(1, 2, 3, 3, px, py);
            end
            if (!loop_mode)
                add_sample(px[3] * 256, py[3] * 256);
        end
        recent_x[0] = recent_x[1]; recent_y[0] = recent_y[1];
        recent_x[1] = recent_x[2]; recent_y[1] = recent_y[2];
        recent_x[2] = px[3];       recent_y[2] = py[3];
        seen_cnt = fin ? 0 : (c >= 4 ? 4 : c + 1);
        if (step_q.size() > 0)
            step_q[step_q.size()-1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sample_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample x=%h y=%h", m_axis_tdata[25:0],
                             m_axis_tdata[51:26]);
            end
            else
            begin
                sample_t s;
                s = sample_q.pop_front();
                if (m_axis_tdata[25:0] !== s.cx || m_axis_tdata[51:26] !== s.cy ||
                    m_axis_tlast !== s.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"sample mismatch: expected x=%h y=%h last=%b, ",
                                  "got x=%h y=%h last=%b"},
                                 s.cx, s.cy, s.last, m_axis_tdata[25:0],
                                 m_axis_tdata[51:26], m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
        m_axis_tready <= rx_quiet ? 1'b1 : ($urandom_range(99) >= 27);

    task automatic reg_write(logic idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == crcg_pkg::REG_PPS)
            seg_len = int'(value[4:0]);
        else
            loop_mode = value[0];
    endtask

    task automatic drain;
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_point(logic [15:0] x, logic [15:0] y, logic fin,
                              logic typed, logic [25:0] ex, logic [25:0] ey);
        sample_t s;
        if (!tx_quiet && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_point(x, y, fin);
        if (typed)
        begin
            s.cx = ex; s.cy = ey; s.last = 1'b1;
            sample_q = {sample_q, s};
        end
        else
            sample_q = {sample_q, step_q};
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    row_t directed[] = '{
        '{16'h7fff, 16'h8000, 1'b1, 1'b1, 26'h07fff00, 26'h3800000},
        '{16'h8000, 16'h7fff, 1'b1, 1'b1, 26'h3800000, 26'h07fff00},
        '{16'h0000, 16'h0000, 1'b1, 1'b1, 26'h0000000, 26'h0000000},
        '{16'hffff, 16'h0001, 1'b1, 1'b1, 26'h3ffff00, 26'h0000100},
        '{16'h0000, 16'h0000, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h7fff, 16'h7fff, 1'b1, 1'b0, 26'h0, 26'h0},
        '{16'h8000, 16'h7fff, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h7fff, 16'h8000, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h8000, 16'h8000, 1'b1, 1'b0, 26'h0, 26'h0},
        '{16'h0005, 16'hfffb, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h7fff, 16'h0000, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h8000, 16'h1234, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h0100, 16'h8000, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'hff00, 16'h7fff, 1'b0, 1'b0, 26'h0, 26'h0},
        '{16'h5555, 16'haaaa, 1'b1, 1'b0, 26'h0, 26'h0}
    };

    int lens[10] = '{1, 2, 0, 16, 3, 31, 4, 2, 1, 5};

    initial
    begin
        int left;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; seen_cnt = 0; seg_len = 16; loop_mode = 1'b0;
        rx_quiet = 1'b0; tx_quiet = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_point(directed[i].px, directed[i].py, directed[i].fin,
                       directed[i].typed, directed[i].ex, directed[i].ey);
        s_axis_tvalid <= 1'b0;
        drain();
        reg_write(crcg_pkg::REG_PPS, 32'd3);
        reg_write(crcg_pkg::REG_CLOSED, 32'd1);
        foreach (directed[i])
            send_point(directed[i].px, directed[i].py, directed[i].fin, 1'b0, '0, '0);
        s_axis_tvalid <= 1'b0;
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            reg_write(crcg_pkg::REG_PPS, 32'(lens[ph]));
            reg_write(crcg_pkg::REG_CLOSED, ph == 9 ? 32'd1 : 32'($urandom_range(1)));
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3);
            left = 34;
            while (left > 0)
            begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
                for (int j = 0; j < len && left > 0; j++, left--)
                    send_point(rand_coord(), rand_coord(), j == len - 1, 1'b0, '0, '0);
            end
            s_axis_tvalid <= 1'b0;
            drain();
        end

        if (errors == 0 && sample_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
